>>> hw/rtl/binary_image_rle_framer_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for binary_image_rle_framer
// Concurrent assertion shorthands used by the top-level RTL file.
// ---------------------------------------------------------------------------
`ifndef BINARY_IMAGE_RLE_FRAMER_MACROS_SVH
`define BINARY_IMAGE_RLE_FRAMER_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define BIR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define BIR_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hw/rtl/bir_pkg.sv
// ---------------------------------------------------------------------------
// bir_pkg
// Shared constants, types and helpers of the binary image RLE framer.
// ---------------------------------------------------------------------------
package bir_pkg;

   // Header and stream codes
   localparam logic [7:0] HDR_SYNC0 = 8'h7A;
   localparam logic [7:0] HDR_SYNC1 = 8'h21;
   localparam logic [7:0] MARK_BASE = 8'd200;
   localparam logic [7:0] RUN_CAP   = 8'd190;
   localparam logic [5:0] CHUNK_MAX = 6'd55;
   localparam logic [5:0] CHUNK_MIN = 6'd1;

   // Register reset values
   localparam logic [7:0] WIDTH_RST     = 8'd188;
   localparam logic [7:0] HEIGHT_RST    = 8'd120;
   localparam logic [7:0] THRESHOLD_RST = 8'd128;
   localparam logic [5:0] CHUNKS_RST    = 6'd10;

   // Word counts
   localparam logic [2:0] HDR_WORDS = 3'd7;

   // Input item kinds
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   // Register map
   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_THRESHOLD    = 2'd2,
      REG_CHUNK_TOTAL  = 2'd3
   } reg_index_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;   // item taken this cycle
      logic emit;     // move buffered words into the output register
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic pix_has_words;   // current pixel item produces at least one word
      logic emit_final;      // last word of the item is loaded this cycle
      logic div_busy;        // chunk length division running
   } dp_status_type;

   // Bound the chunk count to the supported range
   function automatic logic [5:0] clamp_chunks(input logic [5:0] total);
      logic [5:0] c;
      c = total;
      if (c < CHUNK_MIN) begin
         c = CHUNK_MIN;
      end
      if (c > CHUNK_MAX) begin
         c = CHUNK_MAX;
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/bir_req_if.sv
// ---------------------------------------------------------------------------
// bir_req_if
// Input channel: frame start or grayscale pixel words.
// ---------------------------------------------------------------------------
interface bir_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] pixel;

   modport source (output valid, output kind, output pixel, input ready);
   modport sink   (input valid, input kind, input pixel, output ready);
endinterface

>>> hw/rtl/bir_rsp_if.sv
// ---------------------------------------------------------------------------
// bir_rsp_if
// Result channel: one byte of the coded stream per word.
// ---------------------------------------------------------------------------
interface bir_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic       last;

   modport source (output valid, output byte_out, output last, input ready);
   modport sink   (input valid, input byte_out, input last, output ready);
endinterface

>>> hw/rtl/bir_csr_if.sv
// ---------------------------------------------------------------------------
// bir_csr_if
// Register write channel: register index and write data.
// ---------------------------------------------------------------------------
interface bir_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/bir_div.sv
// ---------------------------------------------------------------------------
// bir_div
// Restoring divider, one quotient bit per cycle; holds the chunk length.
// ---------------------------------------------------------------------------
module bir_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [5:0]  divisor,
   output logic        busy,
   output logic [15:0] quotient
);

   logic        busy_ff, busy_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] dq_ff, dq_in;
   logic [5:0]  rem_ff, rem_in;
   logic [5:0]  dvs_ff, dvs_in;
   logic [6:0]  trial;
   logic        ge;

   // One shift-subtract step
   always_comb begin
      trial   = {rem_ff, dq_ff[15]};
      ge      = (trial >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd15;
         dq_in   = dividend;
         rem_in  = 6'd0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 6'(trial - {1'b0, dvs_ff}) : trial[5:0];
         dq_in  = {dq_ff[14:0], ge};
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= 4'd0;
         dq_ff   <= 16'd0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         dq_ff   <= dq_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = dq_ff;

endmodule

>>> hw/rtl/bir_dpath.sv
// ---------------------------------------------------------------------------
// bir_dpath
// Registers, run and chunk state, word buffer and output register.
// ---------------------------------------------------------------------------
module bir_dpath (
   input  logic                  clock,
   input  logic                  reset,
   input  bir_pkg::ctrl_cmd_type cmd,
   output bir_pkg::dp_status_type stat,
   input  logic                  req_kind,
   input  logic [7:0]            req_pixel,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [7:0]            csr_data,
   output logic                  csr_ready,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_byte_out,
   output logic                  rsp_last,
   input  logic                  rsp_ready
);

   // Registers
   logic [7:0]  width_ff, width_in;
   logic [7:0]  height_ff, height_in;
   logic [7:0]  thresh_ff, thresh_in;
   logic [5:0]  chunks_ff, chunks_in;
   // Coding state
   logic [7:0]  run_ff, run_in;
   logic        prev_white_ff, prev_white_in;
   logic [15:0] pic_ff, pic_in;
   logic [5:0]  idx_ff, idx_in;
   // Word buffer
   logic        hdr_mode_ff, hdr_mode_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  pbuf_ff [3];
   logic [7:0]  pbuf_in [3];
   // Output register
   logic        out_valid_ff, out_valid_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;

   // Pixel decode
   logic        white, change, chunk_end, cap, has_pair;
   logic [7:0]  run_a, marker, p0, p1;
   logic [15:0] pic_nxt, chunk_len;
   logic [5:0]  idx_nxt, chunks_eff;
   logic        div_start, div_busy;
   logic [15:0] frame_area;
   logic        slot_free, load;
   logic        final_word;
   logic [7:0]  word_sel;

   assign chunks_eff = bir_pkg::clamp_chunks(chunks_ff);
   assign frame_area = {8'd0, width_ff} * {8'd0, height_ff};
   assign div_start  = cmd.accept && (req_kind == bir_pkg::KIND_FRAME);

   bir_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (frame_area),
      .divisor  (chunks_eff),
      .busy     (div_busy),
      .quotient (chunk_len)
   );

   // Classify pixel and work out the words it causes
   always_comb begin
      white     = (req_pixel > thresh_ff);
      change    = (white != prev_white_ff);
      run_a     = change ? 8'd1 : 8'(run_ff + 8'd1);
      pic_nxt   = 16'(pic_ff + 16'd1);
      chunk_end = (chunk_len != 16'd0) && (pic_nxt == chunk_len);
      idx_nxt   = 6'(idx_ff + 6'd1);
      marker    = 8'(bir_pkg::MARK_BASE + {2'b00, idx_nxt});
      cap       = !chunk_end && (run_a == bir_pkg::RUN_CAP);
      has_pair  = chunk_end || cap;
      p0        = chunk_end ? run_a : bir_pkg::RUN_CAP;
      p1        = chunk_end ? marker : 8'd0;
   end

   // Pick the next word to send
   always_comb begin
      word_sel = 8'd0;
      if (hdr_mode_ff) begin
         unique case (pos_ff)
            3'd0:    word_sel = bir_pkg::HDR_SYNC0;
            3'd1:    word_sel = bir_pkg::HDR_SYNC1;
            3'd2:    word_sel = width_ff;
            3'd3:    word_sel = height_ff;
            3'd4:    word_sel = bir_pkg::HDR_SYNC0;
            3'd5:    word_sel = bir_pkg::HDR_SYNC1;
            default: word_sel = 8'(bir_pkg::MARK_BASE + {2'b00, chunks_eff});
         endcase
      end else begin
         unique case (pos_ff[1:0])
            2'd0:    word_sel = pbuf_ff[0];
            2'd1:    word_sel = pbuf_ff[1];
            default: word_sel = pbuf_ff[2];
         endcase
      end
   end

   assign slot_free  = !out_valid_ff || rsp_ready;
   assign load       = cmd.emit && slot_free;
   assign final_word = (3'(pos_ff + 3'd1) == cnt_ff);

   // Next-state logic
   always_comb begin
      width_in      = width_ff;
      height_in     = height_ff;
      thresh_in     = thresh_ff;
      chunks_in     = chunks_ff;
      run_in        = run_ff;
      prev_white_in = prev_white_ff;
      pic_in        = pic_ff;
      idx_in        = idx_ff;
      hdr_mode_in   = hdr_mode_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      pbuf_in       = pbuf_ff;
      out_valid_in  = out_valid_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;

      // Register writes
      if (csr_valid) begin
         unique case (bir_pkg::reg_index_type'(csr_index))
            bir_pkg::REG_FRAME_WIDTH:  width_in  = csr_data;
            bir_pkg::REG_FRAME_HEIGHT: height_in = csr_data;
            bir_pkg::REG_THRESHOLD:    thresh_in = csr_data;
            bir_pkg::REG_CHUNK_TOTAL:  chunks_in = csr_data[5:0];
            default:                   width_in  = width_ff;
         endcase
      end

      // Take an item
      if (cmd.accept) begin
         pos_in = 3'd0;
         if (req_kind == bir_pkg::KIND_FRAME) begin
            hdr_mode_in   = 1'b1;
            cnt_in        = bir_pkg::HDR_WORDS;
            run_in        = 8'd0;
            prev_white_in = 1'b1;
            pic_in        = 16'd0;
            idx_in        = 6'd0;
         end else begin
            hdr_mode_in = 1'b0;
            cnt_in      = {1'b0, has_pair, change};
            pbuf_in[0]  = change ? run_ff : p0;
            pbuf_in[1]  = change ? p0 : p1;
            pbuf_in[2]  = p1;
            if (chunk_end) begin
               idx_in        = idx_nxt;
               run_in        = 8'd0;
               pic_in        = 16'd0;
               prev_white_in = 1'b1;
            end else begin
               run_in        = cap ? 8'd0 : run_a;
               pic_in        = pic_nxt;
               prev_white_in = white;
            end
         end
      end

      // Drain the output register, then refill it from the buffer
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         out_valid_in = 1'b1;
         out_byte_in  = word_sel;
         out_last_in  = final_word;
         pos_in       = 3'(pos_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= bir_pkg::WIDTH_RST;
         height_ff     <= bir_pkg::HEIGHT_RST;
         thresh_ff     <= bir_pkg::THRESHOLD_RST;
         chunks_ff     <= bir_pkg::CHUNKS_RST;
         run_ff        <= 8'd0;
         prev_white_ff <= 1'b1;
         pic_ff        <= 16'd0;
         idx_ff        <= 6'd0;
         hdr_mode_ff   <= 1'b0;
         cnt_ff        <= 3'd0;
         pos_ff        <= 3'd0;
         out_valid_ff  <= 1'b0;
      end else begin
         width_ff      <= width_in;
         height_ff     <= height_in;
         thresh_ff     <= thresh_in;
         chunks_ff     <= chunks_in;
         run_ff        <= run_in;
         prev_white_ff <= prev_white_in;
         pic_ff        <= pic_in;
         idx_ff        <= idx_in;
         hdr_mode_ff   <= hdr_mode_in;
         cnt_ff        <= cnt_in;
         pos_ff        <= pos_in;
         out_valid_ff  <= out_valid_in;
      end
      pbuf_ff     <= pbuf_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign stat.pix_has_words = change || has_pair;
   assign stat.emit_final    = load && final_word;
   assign stat.div_busy      = div_busy;

   assign csr_ready    = 1'b1;
   assign rsp_valid    = out_valid_ff;
   assign rsp_byte_out = out_byte_ff;
   assign rsp_last     = out_last_ff;

endmodule

>>> hw/rtl/bir_ctrl.sv
// ---------------------------------------------------------------------------
// bir_ctrl
// Item sequencer: takes one item, drains its words, waits for the divider if busy.
// ---------------------------------------------------------------------------
module bir_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_kind,
   output logic                   req_ready,
   input  bir_pkg::dp_status_type stat,
   output bir_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_DIV
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      emit_ff, emit_in;
   logic      accept;

   assign accept = ready_ff && req_valid;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind == bir_pkg::KIND_FRAME || stat.pix_has_words) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (stat.emit_final) begin
               state_in = stat.div_busy ? ST_DIV : ST_IDLE;
            end
         end
         ST_DIV: begin
            if (!stat.div_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      ready_in = (state_in == ST_IDLE);
      emit_in  = (state_in == ST_EMIT);
   end

   // Hold state and registered strobes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
         emit_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         emit_ff  <= emit_in;
      end
   end

   assign req_ready  = ready_ff;
   assign cmd.accept = accept;
   assign cmd.emit   = emit_ff;

endmodule

>>> hw/rtl/binary_image_rle_framer.sv
// ---------------------------------------------------------------------------
// binary_image_rle_framer
// Thresholds grayscale pixels and sends run-length coded frames as bytes.
// Usage:
//   req_bus carries one word per item: kind 0 starts a frame, kind 1 is a
//   pixel in raster order. rsp_bus returns the coded bytes, with last set on
//   the final byte caused by an item. csr_bus writes the four registers
//   (width, height, threshold, chunk count); it is always ready and must be
//   written only while no item is in flight.
//   Flow: an item is taken, then each byte it causes is loaded into the
//   output register in turn, waiting while rsp_bus stalls; req_bus.ready
//   stays low until the last byte is loaded, but a pixel that causes no
//   byte leaves it high. A frame start sends 7 header bytes and holds
//   req_bus.ready low until the chunk length divider is done. The first byte
//   goes through the registered emit strobe and then the output register.
//   The last byte of an item may still wait there while the next is taken.
//   When rsp_bus stalls, bytes hold in the output register; nothing is lost.
//   Reset (synchronous, active high) restores register defaults, clears
//   run and chunk state and sets chunk length to zero until a frame start.
// ---------------------------------------------------------------------------
`include "binary_image_rle_framer_macros.svh"

module binary_image_rle_framer (
   input logic        clock,
   input logic        reset,
   bir_req_if.sink    req_bus,
   bir_rsp_if.source  rsp_bus,
   bir_csr_if.sink    csr_bus
);

   bir_pkg::ctrl_cmd_type  cmd;
   bir_pkg::dp_status_type stat;
   logic                   frame_taken;
   logic                   dividing;

   bir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bir_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_kind     (req_bus.kind),
      .req_pixel    (req_bus.pixel),
      .csr_valid    (csr_bus.valid),
      .csr_index    (csr_bus.index),
      .csr_data     (csr_bus.data),
      .csr_ready    (csr_bus.ready),
      .rsp_valid    (rsp_bus.valid),
      .rsp_byte_out (rsp_bus.byte_out),
      .rsp_last     (rsp_bus.last),
      .rsp_ready    (rsp_bus.ready)
   );

   // Checks
   assign frame_taken = cmd.accept && (req_bus.kind == bir_pkg::KIND_FRAME);
   assign dividing    = stat.div_busy;

   `BIR_ASSERT_NEVER(a_ready_div, clock, reset, req_bus.ready && dividing, "ready while dividing")
   `BIR_ASSERT(a_frame_starts_div, clock, reset, frame_taken |=> dividing, "divider not started")
   `BIR_ASSERT(a_frame_blocks, clock, reset, frame_taken |=> !req_bus.ready, "input not held")
   `BIR_ASSERT_NEVER(a_emit_ready, clock, reset, cmd.emit && req_bus.ready, "emit while ready")

endmodule

>>> test/rle_stream_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rle_stream_checker
// Watches the request, result and register channels of the framer. Keeps
// its own copy of the registers and of the run and chunk state, works out
// the coded bytes each accepted word should cause, and compares every
// delivered byte with the oldest one still owed.
// ---------------------------------------------------------------------------
module rle_stream_checker (
   input  logic clock,
   input  logic reset,
   bir_req_if   req_mon,
   bir_rsp_if   rsp_mon,
   bir_csr_if   csr_mon,
   output int   fail_count,
   output int   outstanding,
   output int   bytes_checked,
   output int   marker_count,
   output int   cap_count
);

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } coded_byte_type;

   // Bytes owed by the framer, oldest first
   coded_byte_type owed_bytes_q[$];

   // Register copy
   logic [7:0] cfg_width;
   logic [7:0] cfg_height;
   logic [7:0] cfg_threshold;
   logic [5:0] cfg_chunks;

   // Run and chunk state
   logic [7:0]  run_len;
   logic        prev_white;
   logic [15:0] in_chunk;
   logic [15:0] chunk_len;
   logic [5:0]  chunk_idx;

   initial begin
      fail_count    = 0;
      bytes_checked = 0;
      marker_count  = 0;
      cap_count     = 0;
   end

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string what, input int want, input int got);
      $display("%0t mismatch on %s: expected %0d, got %0d (byte %0d)",
               $realtime, what, want, got, bytes_checked);
      fail_count++;
   endtask

   // Work out the coded bytes of one word and queue them
   task automatic encode_item(input logic kind, input logic [7:0] pix);
      logic [7:0]     coded [0:6];
      int             n;
      logic           white;
      logic [5:0]     chunks;
      logic [15:0]    area;
      coded_byte_type entry;
      n = 0;
      if (kind == bir_pkg::KIND_FRAME) begin
         // bound the chunk count before it goes into the header and divider
         chunks = cfg_chunks;
         if (chunks < bir_pkg::CHUNK_MIN) begin
            chunks = bir_pkg::CHUNK_MIN;
         end
         if (chunks > bir_pkg::CHUNK_MAX) begin
            chunks = bir_pkg::CHUNK_MAX;
         end
         coded[0] = bir_pkg::HDR_SYNC0;
         coded[1] = bir_pkg::HDR_SYNC1;
         coded[2] = cfg_width;
         coded[3] = cfg_height;
         coded[4] = bir_pkg::HDR_SYNC0;
         coded[5] = bir_pkg::HDR_SYNC1;
         coded[6] = bir_pkg::MARK_BASE + {2'b00, chunks};
         n = 7;
         area       = {8'd0, cfg_width} * {8'd0, cfg_height};
         chunk_len  = area / {10'd0, chunks};
         run_len    = 8'd0;
         prev_white = 1'b1;
         in_chunk   = 16'd0;
         chunk_idx  = 6'd0;
      end else begin
         white    = (pix > cfg_threshold);
         in_chunk = in_chunk + 16'd1;
         // extend the run or close it on a color change
         if (white == prev_white) begin
            run_len = run_len + 8'd1;
         end else begin
            coded[n] = run_len;
            n++;
            run_len = 8'd1;
         end
         // close the chunk: flush the run, send the marker, restart on white
         if (chunk_len != 16'd0 && in_chunk == chunk_len) begin
            chunk_idx = chunk_idx + 6'd1;
            coded[n]  = run_len;
            n++;
            coded[n]  = bir_pkg::MARK_BASE + {2'b00, chunk_idx};
            n++;
            white    = 1'b1;
            run_len  = 8'd0;
            in_chunk = 16'd0;
            marker_count++;
         end
         // split a run that hits the cap
         if (run_len == bir_pkg::RUN_CAP) begin
            coded[n] = bir_pkg::RUN_CAP;
            n++;
            coded[n] = 8'd0;
            n++;
            run_len = 8'd0;
            cap_count++;
         end
         prev_white = white;
      end
      for (int i = 0; i < n; i++) begin
         entry.code = coded[i];
         entry.last = (i == n - 1);
         owed_bytes_q.push_back(entry);
      end
   endtask

   always @(posedge clock) begin
      coded_byte_type want;
      if (reset) begin
         cfg_width     = bir_pkg::WIDTH_RST;
         cfg_height    = bir_pkg::HEIGHT_RST;
         cfg_threshold = bir_pkg::THRESHOLD_RST;
         cfg_chunks    = bir_pkg::CHUNKS_RST;
         run_len       = 8'd0;
         prev_white    = 1'b1;
         in_chunk      = 16'd0;
         chunk_len     = 16'd0;
         chunk_idx     = 6'd0;
         owed_bytes_q.delete();
      end else begin
         // compare a delivered word with the oldest owed byte
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_bytes_q.size() == 0) begin
               report_mismatch("byte with nothing owed", -1, rsp_mon.byte_out);
            end else begin
               want = owed_bytes_q.pop_front();
               if (rsp_mon.byte_out !== want.code) begin
                  report_mismatch("byte_out", want.code, rsp_mon.byte_out);
               end
               if (rsp_mon.last !== want.last) begin
                  report_mismatch("last", want.last, rsp_mon.last);
               end
               bytes_checked++;
            end
         end
         // track register writes
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               bir_pkg::REG_FRAME_WIDTH: begin
                  cfg_width = csr_mon.data;
               end
               bir_pkg::REG_FRAME_HEIGHT: begin
                  cfg_height = csr_mon.data;
               end
               bir_pkg::REG_THRESHOLD: begin
                  cfg_threshold = csr_mon.data;
               end
               bir_pkg::REG_CHUNK_TOTAL: begin
                  cfg_chunks = csr_mon.data[5:0];
               end
               default: begin
               end
            endcase
         end
         // predict the bytes of an accepted word
         if (req_mon.valid && req_mon.ready) begin
            encode_item(req_mon.kind, req_mon.pixel);
         end
      end
      outstanding <= owed_bytes_q.size();
   end

endmodule

>>> test/tb_binary_image_rle_framer.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_binary_image_rle_framer
// Drives frame starts and pixel runs into the framer under several register
// settings, with bursty input and a stalling output, and leaves the byte
// checking to rle_stream_checker. Gives the verdict once all bytes are in.
// ---------------------------------------------------------------------------
module tb_binary_image_rle_framer;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_ITEMS  = 280;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_pattern_type;
   typedef enum {SCN_SMALL, SCN_LARGE, SCN_NO_CHUNK, SCN_LONG_RUN, SCN_INDEX_WRAP} scenario_type;

   logic clock = 1'b0;
   logic reset;

   bir_req_if req_bus ();
   bir_rsp_if rsp_bus ();
   bir_csr_if csr_bus ();

   int fail_count;
   int outstanding;
   int bytes_checked;
   int marker_count;
   int cap_count;

   int                items_sent   = 0;
   int                frames_sent  = 0;
   int                phases_run   = 0;
   int                burst_left   = 0;
   bit                gapless      = 1'b0;
   int                idle_cycles  = 0;
   int                stall_cycles = 0;
   stall_pattern_type stall_mode   = STALL_NONE;
   logic [7:0]        cur_threshold = bir_pkg::THRESHOLD_RST;

   always #5 clock = ~clock;

   binary_image_rle_framer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   rle_stream_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .csr_mon       (csr_bus),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .bytes_checked (bytes_checked),
      .marker_count  (marker_count),
      .cap_count     (cap_count)
   );

   // Stall the result side, switching pattern every so often
   always @(posedge clock) begin
      if (stall_cycles == 0) begin
         stall_mode   <= stall_pattern_type'($urandom_range(0, 3));
         stall_cycles <= $urandom_range(20, 120);
      end else begin
         stall_cycles <= stall_cycles - 1;
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_bus.ready <= 1'b1;
         end
         STALL_LIGHT: begin
            rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         end
         STALL_PERIODIC: begin
            rsp_bus.ready <= (stall_cycles % 4 == 0);
         end
         default: begin
            rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         end
      endcase
   end

   // Stop the run when no channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
         $display("FAIL binary_image_rle_framer");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one word and hold it until taken; idle between bursts
   task automatic send_item(input logic kind, input logic [7:0] pix);
      int gap;
      if (!gapless && burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.pixel <= pix;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end
      items_sent++;
      if (kind == bir_pkg::KIND_FRAME) begin
         frames_sent++;
      end
   endtask

   // Drop valid and wait until every owed byte is in and the block is quiet
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic put_reg(input bir_pkg::reg_index_type idx, input logic [7:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   // Write all four registers while the block is idle
   task automatic load_config(input logic [7:0] w, input logic [7:0] h,
                              input logic [7:0] th, input logic [7:0] chunks);
      settle_block();
      put_reg(bir_pkg::REG_FRAME_WIDTH, w);
      put_reg(bir_pkg::REG_FRAME_HEIGHT, h);
      put_reg(bir_pkg::REG_THRESHOLD, th);
      put_reg(bir_pkg::REG_CHUNK_TOTAL, chunks);
      csr_bus.valid <= 1'b0;
      cur_threshold = th;
   endtask

   // Pick a pixel of the wanted color, now and then right at the threshold
   function automatic logic [7:0] shade(input bit want_white);
      if (want_white && cur_threshold != 8'hFF) begin
         if ($urandom_range(0, 7) == 0) begin
            return cur_threshold + 8'd1;
         end
         return 8'($urandom_range(cur_threshold + 1, 255));
      end
      if (!want_white) begin
         if ($urandom_range(0, 7) == 0) begin
            return cur_threshold;
         end
         return 8'($urandom_range(0, cur_threshold));
      end
      return 8'($urandom);
   endfunction

   // Send pixels as runs of alternating color, with optional noise words
   task automatic send_runs(input int count, input int max_run, input int min_run,
                            input bit with_noise);
      bit color;
      int run;
      int sent;
      color = $urandom_range(0, 1);
      sent  = 0;
      while (sent < count) begin
         run = $urandom_range(min_run, max_run);
         for (int k = 0; k < run && sent < count; k++) begin
            if (with_noise && $urandom_range(0, 19) == 0) begin
               send_item(bir_pkg::KIND_PIXEL, 8'($urandom));
            end else begin
               send_item(bir_pkg::KIND_PIXEL, shade(color));
            end
            sent++;
         end
         color = ~color;
      end
   endtask

   function automatic scenario_type pick_scenario();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 6) begin
         return SCN_SMALL;
      end else if (r == 7) begin
         return SCN_LARGE;
      end else if (r == 8) begin
         return SCN_NO_CHUNK;
      end
      return SCN_INDEX_WRAP;
   endfunction

   // One register setting, a frame start (sometimes a second one midway) and a stretch of pixels
   task automatic run_scenario(input scenario_type scn);
      logic [7:0] w;
      logic [7:0] h;
      logic [7:0] th;
      logic [7:0] chunks;
      int         count;
      gapless = ($urandom_range(0, 2) == 0);
      th      = 8'($urandom);
      case (scn)
         SCN_LARGE: begin
            w      = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(100, 255));
            h      = ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom_range(100, 255));
            chunks = 8'($urandom_range(1, 55));
            load_config(w, h, th, chunks);
            send_item(bir_pkg::KIND_FRAME, 8'($urandom));
            send_runs($urandom_range(20, 40), 40, 1, 1'b1);
         end
         SCN_NO_CHUNK: begin
            // fewer pixels than chunks: chunk length is zero, runs never flush
            h      = 8'($urandom_range(1, 4));
            chunks = 8'($urandom_range(h + 1, 63));
            load_config(8'd1, h, th, chunks);
            send_item(bir_pkg::KIND_FRAME, 8'($urandom));
            send_runs($urandom_range(30, 60), 60, 1, 1'b1);
         end
         SCN_LONG_RUN: begin
            // 16 x 24 in two chunks gives chunks of 192 pixels: the run caps at 190 first
            th = 8'($urandom_range(1, 254));
            load_config(8'd16, 8'd24, th, 8'd2);
            send_item(bir_pkg::KIND_FRAME, 8'($urandom));
            send_runs(192, 192, 192, 1'b0);
         end
         SCN_INDEX_WRAP: begin
            // one-pixel chunks carry the chunk number past its 6-bit range
            load_config(8'd1, 8'd1, th, 8'd1);
            send_item(bir_pkg::KIND_FRAME, 8'($urandom));
            send_runs(66, 3, 1, 1'b1);
         end
         default: begin
            w      = 8'($urandom_range(1, 8));
            h      = 8'($urandom_range(1, 8));
            chunks = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 12));
            load_config(w, h, th, chunks);
            send_item(bir_pkg::KIND_FRAME, 8'($urandom));
            count = $urandom_range(20, 60);
            send_runs(count / 2, 6, 1, 1'b1);
            if ($urandom_range(0, 3) == 0) begin
               send_item(bir_pkg::KIND_FRAME, 8'($urandom));
            end
            send_runs(count - count / 2, 6, 1, 1'b1);
         end
      endcase
      phases_run++;
   endtask

   initial begin
      int random_start;
      req_bus.valid <= 1'b0;
      req_bus.kind  <= bir_pkg::KIND_PIXEL;
      req_bus.pixel <= 8'd0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= bir_pkg::REG_FRAME_WIDTH;
      csr_bus.data  <= 8'd0;
      reset         <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // pixels before any frame start: chunk length is still zero
      send_item(bir_pkg::KIND_PIXEL, 8'd0);
      send_item(bir_pkg::KIND_PIXEL, 8'd255);
      send_item(bir_pkg::KIND_PIXEL, bir_pkg::THRESHOLD_RST);
      send_item(bir_pkg::KIND_PIXEL, bir_pkg::THRESHOLD_RST + 8'd1);
      // header with the reset register values
      send_item(bir_pkg::KIND_FRAME, 8'd0);
      send_item(bir_pkg::KIND_PIXEL, 8'd255);
      send_item(bir_pkg::KIND_PIXEL, 8'd0);

      // chunk count zero used as one, one-pixel frame, lowest threshold
      load_config(8'd1, 8'd1, 8'd0, 8'd0);
      send_item(bir_pkg::KIND_FRAME, 8'd255);
      send_item(bir_pkg::KIND_PIXEL, 8'd0);
      send_item(bir_pkg::KIND_PIXEL, 8'd1);
      send_item(bir_pkg::KIND_PIXEL, 8'd255);

      // largest frame, chunk count above the bound, nothing counts as white
      load_config(8'd255, 8'd255, 8'd255, 8'd63);
      send_item(bir_pkg::KIND_FRAME, 8'd0);
      send_item(bir_pkg::KIND_PIXEL, 8'd255);
      send_item(bir_pkg::KIND_PIXEL, 8'd0);

      // fewer pixels than chunks: chunk length zero
      load_config(8'd2, 8'd2, 8'd100, 8'd5);
      send_item(bir_pkg::KIND_FRAME, 8'd0);
      send_item(bir_pkg::KIND_PIXEL, 8'd101);
      send_item(bir_pkg::KIND_PIXEL, 8'd100);

      // three-pixel chunks closing on a white run and on a black run
      load_config(8'd3, 8'd2, 8'd50, 8'd2);
      send_item(bir_pkg::KIND_FRAME, 8'd0);
      send_item(bir_pkg::KIND_PIXEL, 8'd51);
      send_item(bir_pkg::KIND_PIXEL, 8'd51);
      send_item(bir_pkg::KIND_PIXEL, 8'd51);
      send_item(bir_pkg::KIND_PIXEL, 8'd0);
      send_item(bir_pkg::KIND_PIXEL, 8'd0);
      send_item(bir_pkg::KIND_PIXEL, 8'd0);
      send_item(bir_pkg::KIND_FRAME, 8'd0);
      send_item(bir_pkg::KIND_PIXEL, 8'd0);

      // random settings and pixel streams
      random_start = items_sent;
      run_scenario(SCN_LONG_RUN);
      run_scenario(SCN_INDEX_WRAP);
      while (items_sent - random_start < RANDOM_ITEMS) begin
         run_scenario(pick_scenario());
      end

      settle_block();
      $display("covered %0d words in %0d frames over %0d random settings, %0d bytes checked",
               items_sent, frames_sent, phases_run, bytes_checked);
      $display("predicted %0d chunk markers and %0d capped runs", marker_count, cap_count);
      if (fail_count == 0) begin
         $display("PASS binary_image_rle_framer");
      end else begin
         $display("FAIL binary_image_rle_framer");
      end
      $finish;
   end

endmodule
